FILE: hw/rtl/srtt_pkg.sv
// package for signed_radix_to_text: constants, state type and alphabet lookup
package srtt_pkg;

  localparam int MAX_RADIX    = 16;
  localparam int NUMBER_WIDTH = 32;
  localparam int DIGIT_DEPTH  = NUMBER_WIDTH;
  localparam int CNT_W        = $clog2(DIGIT_DEPTH + 1);
  localparam int ADDR_W       = $clog2(DIGIT_DEPTH);
  localparam int RADIX_W      = 5;
  localparam int DIGIT_W      = 4;
  localparam int CHAR_W       = 8;
  localparam int WORD_W       = 64;
  localparam int CHUNK_BITS   = 8;
  localparam int CHUNKS       = NUMBER_WIDTH / CHUNK_BITS;
  localparam int STEP_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
  localparam logic [WORD_W-1:0]  ALPHA_LO_RESET = 64'd3978425819141910832;
  localparam logic [WORD_W-1:0]  ALPHA_HI_RESET = 64'd7378413942531504440;

  localparam logic [1:0] CFG_RADIX    = 2'd0;
  localparam logic [1:0] CFG_ALPHA_LO = 2'd1;
  localparam logic [1:0] CFG_ALPHA_HI = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  function automatic logic [CHAR_W-1:0] alpha_char(
    input logic [WORD_W-1:0]  lo,
    input logic [WORD_W-1:0]  hi,
    input logic [DIGIT_W-1:0] idx
  );
    logic [WORD_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

FILE: hw/rtl/signed_radix_to_text.sv
// top level: signed number to text in a configured radix and alphabet
//
// channel  direction  ports                           transfer
// input    in         start, busy, in_number          start high and busy low
// result   out        out_valid, out_character,       any cycle with out_valid high
//                     out_last
// config   in         cfg_we, cfg_index, cfg_wdata    any cycle with cfg_we high
//
// alphabet check: one character in use per cycle, each vs the sign chars and all later chars in use
// conversion: 8 quotient bits a cycle from one narrow divider, one digit per full pass over the magnitude
// output: a sign slot (registered digit read), then one digit character per cycle
// busy is high throughout
// reset is synchronous active low; results cannot be stalled by the receiver
module signed_radix_to_text (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [srtt_pkg::NUMBER_WIDTH-1:0] in_number,
  output logic                                    out_valid,
  output logic [srtt_pkg::CHAR_W-1:0]             out_character,
  output logic                                    out_last,
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_index,
  input  logic [srtt_pkg::WORD_W-1:0]             cfg_wdata
);
  import srtt_pkg::*;

  state_t state_r, state_nxt;

  logic [RADIX_W-1:0]      radix_r;
  logic [WORD_W-1:0]       alpha_lo_r;
  logic [WORD_W-1:0]       alpha_hi_r;

  logic [NUMBER_WIDTH-1:0] mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]      idx_r, idx_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DIGIT_W-1:0]      rem_r, rem_nxt;

  logic [DIGIT_W-1:0]      digit_mem [DIGIT_DEPTH];
  logic [DIGIT_W-1:0]      rd_r;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;

  logic                    accept;
  logic                    radix_bad;
  logic                    char_bad;
  logic                    check_last;
  logic                    digit_done;
  logic                    conv_done;
  logic [CHAR_W-1:0]       cur_char;
  logic [CHUNK_BITS-1:0]   q_chunk;
  logic [DIGIT_W-1:0]      rem_step;
  logic [NUMBER_WIDTH-1:0] quotient;

  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RESET;
      alpha_lo_r <= ALPHA_LO_RESET;
      alpha_hi_r <= ALPHA_HI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:    radix_r    <= cfg_wdata[RADIX_W-1:0];
        CFG_ALPHA_LO: alpha_lo_r <= cfg_wdata;
        CFG_ALPHA_HI: alpha_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // radix range check and alphabet check of one character against sign chars and all later chars in use
  always_comb begin
    cur_char  = alpha_char(alpha_lo_r, alpha_hi_r, idx_r);
    radix_bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_RADIX));
    char_bad  = (cur_char == PLUS_CHAR) || (cur_char == MINUS_CHAR);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((RADIX_W'(j) > {1'b0, idx_r}) && (RADIX_W'(j) < radix_r) &&
          (alpha_char(alpha_lo_r, alpha_hi_r, DIGIT_W'(j)) == cur_char)) begin
        char_bad = 1'b1;
      end
    end
    check_last = (({1'b0, idx_r} + RADIX_W'(1)) == radix_r);
  end

  // shared divider: one chunk of quotient bits per cycle
  always_comb begin
    logic [RADIX_W-1:0]    t;
    logic [CHUNK_BITS-1:0] chunk;
    chunk   = mag_r[NUMBER_WIDTH-1 -: CHUNK_BITS];
    t       = {1'b0, rem_r};
    q_chunk = '0;
    for (int k = CHUNK_BITS - 1; k >= 0; k--) begin
      t = {t[RADIX_W-2:0], chunk[k]};
      if (t >= radix_r) begin
        t          = t - radix_r;
        q_chunk[k] = 1'b1;
      end
    end
    rem_step = t[DIGIT_W-1:0];
  end

  generate
    if (CHUNKS > 1) begin : g_shift
      assign quotient = {mag_r[NUMBER_WIDTH-CHUNK_BITS-1:0], q_chunk};
    end else begin : g_one
      assign quotient = q_chunk;
    end
  endgenerate

  assign digit_done = (state_r == ST_DIV) && (step_r == STEP_W'(CHUNKS - 1));
  assign conv_done  = (quotient == '0) || (cnt_r == CNT_W'(DIGIT_DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (radix_bad || char_bad) state_nxt = ST_IDLE;
        else if (check_last)       state_nxt = ST_DIV;
      end
      ST_DIV:   if (digit_done && conv_done) state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_DIGIT;
      ST_DIGIT: if (cnt_r == CNT_W'(1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    wr_en    = 1'b0;
    rd_addr  = ADDR_W'(cnt_r - CNT_W'(1));
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt  = in_number[NUMBER_WIDTH-1];
          mag_nxt  = in_number[NUMBER_WIDTH-1] ? (~in_number + 1'b1) : in_number;
          cnt_nxt  = '0;
          idx_nxt  = '0;
          step_nxt = '0;
          rem_nxt  = '0;
        end
      end
      ST_CHECK: idx_nxt = idx_r + DIGIT_W'(1);
      ST_DIV: begin
        mag_nxt = quotient;
        if (digit_done) begin
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          step_nxt = '0;
          rem_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
          rem_nxt  = rem_step;
        end
      end
      ST_SIGN:  rd_addr = ADDR_W'(cnt_r - CNT_W'(1));
      ST_DIGIT: begin
        rd_addr = ADDR_W'(cnt_r - CNT_W'(2));
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
      step_r  <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt_r[ADDR_W-1:0]] <= rem_step;
    end
    rd_r <= digit_mem[rd_addr];
  end

  // outputs
  always_comb begin
    busy          = (state_r != ST_IDLE);
    out_valid     = 1'b0;
    out_character = '0;
    out_last      = 1'b0;
    case (state_r)
      ST_SIGN: begin
        out_valid     = neg_r;
        out_character = MINUS_CHAR;
      end
      ST_DIGIT: begin
        out_valid     = 1'b1;
        out_character = alpha_char(alpha_lo_r, alpha_hi_r, rd_r);
        out_last      = (cnt_r == CNT_W'(1));
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CHECK)) else $error("accepted number not checked");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy) else $error("busy after last character");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DIGIT_DEPTH)) else $error("digit count overflow");

  a_digit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT) |-> (cnt_r != '0)) else $error("digit output with no digits");
`endif

endmodule
